// ===== hdl/bfb_pkg.sv =====
// Shared types and constants for the framed binary message builder.
package bfb_pkg;

  localparam int unsigned QUEUE_DEPTH = 4;

  localparam logic       MODE_START = 1'b0;
  localparam logic       MODE_DATA  = 1'b1;

  localparam logic [7:0]  SYNC_A   = 8'hFF;
  localparam logic [7:0]  SYNC_B   = 8'h5A;
  localparam logic [7:0]  ETX_BYTE = 8'h33;
  localparam logic [15:0] CRC_POLY = 16'h8408;

  typedef enum logic {
    KIND_START,
    KIND_BYTE
  } bfb_kind_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SYNC_B,
    ST_ID,
    ST_CLASS,
    ST_LEN_LO,
    ST_LEN_HI,
    ST_CRC_LO,
    ST_CRC_HI,
    ST_ETX
  } bfb_step_e;

  typedef struct packed {
    bfb_kind_e   kind;
    logic        last;
    logic [7:0]  msg_id;
    logic [7:0]  msg_class;
    logic [15:0] payload_length;
    logic [7:0]  payload_byte;
  } bfb_cmd_t;

  typedef struct packed {
    logic full;
    logic head_valid;
  } bfb_qstat_t;

endpackage

// ===== hdl/bfb_if.sv =====
// Valid/ready channel interfaces for input items and output bytes.
interface bfb_in_if;
  logic        valid;
  logic        ready;
  logic        mode;
  logic [7:0]  msg_id;
  logic [7:0]  msg_class;
  logic [15:0] payload_length;
  logic [7:0]  payload_byte;

  modport source (output valid, mode, msg_id, msg_class, payload_length, payload_byte,
                  input ready);
  modport sink   (input valid, mode, msg_id, msg_class, payload_length, payload_byte,
                  output ready);
endinterface

interface bfb_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_of_run;
  logic       frame_end;

  modport source (output valid, out_byte, last_of_run, frame_end, input ready);
  modport sink   (input valid, out_byte, last_of_run, frame_end, output ready);
endinterface

// ===== hdl/bfb_front.sv =====
// Front end: accepts items, tracks the open frame and queues commands.
module bfb_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  bfb_in_if.sink            in_i,
  input  bfb_pkg::bfb_qstat_t qstat_i,
  output logic              push_o,
  output bfb_pkg::bfb_cmd_t cmd_o
);

  logic [15:0] remaining_q, remaining_d;
  logic        accept;
  logic        is_start;

  assign in_i.ready = !qstat_i.full;
  assign accept     = in_i.valid && in_i.ready;
  assign is_start   = (in_i.mode == bfb_pkg::MODE_START);

  // drop payload items that arrive outside a frame
  assign push_o = accept && (is_start || (remaining_q != 16'd0));

  always_comb begin
    cmd_o.kind           = is_start ? bfb_pkg::KIND_START : bfb_pkg::KIND_BYTE;
    cmd_o.last           = (remaining_q == 16'd1);
    cmd_o.msg_id         = in_i.msg_id;
    cmd_o.msg_class      = in_i.msg_class;
    cmd_o.payload_length = in_i.payload_length;
    cmd_o.payload_byte   = in_i.payload_byte;
  end

  always_comb begin
    remaining_d = remaining_q;
    if (accept) begin
      if (is_start) begin
        remaining_d = in_i.payload_length;
      end else if (remaining_q != 16'd0) begin
        remaining_d = remaining_q - 16'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      remaining_q <= '0;
    end else begin
      remaining_q <= remaining_d;
    end
  end

endmodule

// ===== hdl/bfb_queue.sv =====
// Short command queue between front end and byte sequencer.
module bfb_queue #(
  parameter int unsigned Depth = bfb_pkg::QUEUE_DEPTH
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  bfb_pkg::bfb_cmd_t   cmd_i,
  input  logic                pop_i,
  output bfb_pkg::bfb_qstat_t qstat_o,
  output bfb_pkg::bfb_cmd_t   head_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  bfb_pkg::bfb_cmd_t mem_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]   count_q, count_d;

  assign qstat_o.full       = (count_q == CntW'(Depth));
  assign qstat_o.head_valid = (count_q != '0);
  assign head_o             = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + CntW'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (!qstat_o.full || pop_i))
    else $error("command queue written while full");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> qstat_o.head_valid)
    else $error("command queue popped while empty");
`endif

endmodule

// ===== hdl/bfb_back.sv =====
// Back end: walks each command through its bytes, runs the CRC, registers the output.
module bfb_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  bfb_pkg::bfb_qstat_t qstat_i,
  input  bfb_pkg::bfb_cmd_t   head_i,
  output logic                pop_o,
  bfb_out_if.source           out_o
);

  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ bfb_pkg::CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  bfb_pkg::bfb_step_e state_q, state_d;
  logic [15:0] crc_q, crc_d;
  logic        out_valid_q;
  logic [7:0]  out_byte_q;
  logic        out_last_q;
  logic        out_fend_q;

  logic        fire;
  logic [7:0]  emit_byte;
  logic        emit_last;
  logic        emit_fend;
  logic        emit_pop;
  logic        len_nonzero;

  assign len_nonzero = (head_i.payload_length != 16'd0);
  assign fire        = qstat_i.head_valid && (!out_valid_q || out_o.ready);
  assign pop_o       = fire && emit_pop;

  // next state
  always_comb begin
    state_d = state_q;
    if (fire) begin
      case (state_q)
        bfb_pkg::ST_IDLE: begin
          if (head_i.kind == bfb_pkg::KIND_START) begin
            state_d = bfb_pkg::ST_SYNC_B;
          end else if (head_i.last) begin
            state_d = bfb_pkg::ST_CRC_LO;
          end
        end
        bfb_pkg::ST_SYNC_B: state_d = bfb_pkg::ST_ID;
        bfb_pkg::ST_ID:     state_d = bfb_pkg::ST_CLASS;
        bfb_pkg::ST_CLASS:  state_d = bfb_pkg::ST_LEN_LO;
        bfb_pkg::ST_LEN_LO: state_d = bfb_pkg::ST_LEN_HI;
        bfb_pkg::ST_LEN_HI: state_d = len_nonzero ? bfb_pkg::ST_IDLE : bfb_pkg::ST_CRC_LO;
        bfb_pkg::ST_CRC_LO: state_d = bfb_pkg::ST_CRC_HI;
        bfb_pkg::ST_CRC_HI: state_d = bfb_pkg::ST_ETX;
        bfb_pkg::ST_ETX:    state_d = bfb_pkg::ST_IDLE;
        default:            state_d = bfb_pkg::ST_IDLE;
      endcase
    end
  end

  // byte, flags and CRC for the current step
  always_comb begin
    emit_byte = '0;
    emit_last = 1'b0;
    emit_fend = 1'b0;
    emit_pop  = 1'b0;
    crc_d     = crc_q;
    case (state_q)
      bfb_pkg::ST_IDLE: begin
        if (head_i.kind == bfb_pkg::KIND_START) begin
          emit_byte = bfb_pkg::SYNC_A;
        end else begin
          emit_byte = head_i.payload_byte;
          crc_d     = crc_byte(crc_q, head_i.payload_byte);
          emit_last = !head_i.last;
          emit_pop  = !head_i.last;
        end
      end
      bfb_pkg::ST_SYNC_B: emit_byte = bfb_pkg::SYNC_B;
      bfb_pkg::ST_ID: begin
        emit_byte = head_i.msg_id;
        crc_d     = crc_byte(16'h0000, head_i.msg_id);
      end
      bfb_pkg::ST_CLASS: begin
        emit_byte = head_i.msg_class;
        crc_d     = crc_byte(crc_q, head_i.msg_class);
      end
      bfb_pkg::ST_LEN_LO: begin
        emit_byte = head_i.payload_length[7:0];
        crc_d     = crc_byte(crc_q, head_i.payload_length[7:0]);
      end
      bfb_pkg::ST_LEN_HI: begin
        emit_byte = head_i.payload_length[15:8];
        crc_d     = crc_byte(crc_q, head_i.payload_length[15:8]);
        emit_last = len_nonzero;
        emit_pop  = len_nonzero;
      end
      bfb_pkg::ST_CRC_LO: emit_byte = crc_q[7:0];
      bfb_pkg::ST_CRC_HI: emit_byte = crc_q[15:8];
      bfb_pkg::ST_ETX: begin
        emit_byte = bfb_pkg::ETX_BYTE;
        emit_last = 1'b1;
        emit_fend = 1'b1;
        emit_pop  = 1'b1;
        crc_d     = '0;
      end
      default: emit_byte = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bfb_pkg::ST_IDLE;
      crc_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (fire) begin
        state_q <= state_d;
        crc_q   <= crc_d;
      end
      if (fire) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_byte_q <= emit_byte;
      out_last_q <= emit_last;
      out_fend_q <= emit_fend;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.out_byte    = out_byte_q;
  assign out_o.last_of_run = out_last_q;
  assign out_o.frame_end   = out_fend_q;

`ifndef SYNTHESIS
  a_busy_has_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != bfb_pkg::ST_IDLE) |-> qstat_i.head_valid)
    else $error("sequencer mid-command without a queued command");
  a_fend_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_fend_q) |-> out_last_q)
    else $error("frame end byte not marked last of run");
  a_pop_ends_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> (out_valid_q && out_last_q && state_q == bfb_pkg::ST_IDLE))
    else $error("command retired without closing its run");
`endif

endmodule

// ===== hdl/binary_frame_builder_crc16_top.sv =====
// Framed binary message builder with reflected CRC-16 (poly 0x8408, init 0).
// A start item (mode 0) yields sync bytes FF 5A, id, class, length low/high;
// payload items (mode 1) pass one byte each, and the last expected byte is
// followed by CRC low, CRC high and ETX 0x33. A zero-length start closes the
// frame at once; payload outside a frame is dropped. The front end accepts one
// item per cycle while the command queue has room; the back-end sequencer emits
// one byte per cycle while a command is queued and the output is not stalled.
module binary_frame_builder_crc16_top #(
  parameter int unsigned QueueDepth = bfb_pkg::QUEUE_DEPTH
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  bfb_in_if.sink     in_i,
  bfb_out_if.source  out_o
);

  logic                push;
  logic                pop;
  bfb_pkg::bfb_cmd_t   push_cmd;
  bfb_pkg::bfb_cmd_t   head_cmd;
  bfb_pkg::bfb_qstat_t qstat;

  bfb_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_i),
    .qstat_i (qstat),
    .push_o  (push),
    .cmd_o   (push_cmd)
  );

  bfb_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .pop_i   (pop),
    .qstat_o (qstat),
    .head_o  (head_cmd)
  );

  bfb_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .qstat_i (qstat),
    .head_i  (head_cmd),
    .pop_o   (pop),
    .out_o   (out_o)
  );

endmodule
